// ===== design/ftpp_pkg.sv =====
// ----------------------------------------------------------------------------
// ftpp_pkg
// Shared types and constants of the file transfer packet parser.
// ----------------------------------------------------------------------------
package ftpp_pkg;

    // Number of size bytes a start packet may carry into the announced size.
    localparam int SIZE_FIELD_BYTES = 4;
    localparam int SIZE_TAKE = (SIZE_FIELD_BYTES < 4) ? SIZE_FIELD_BYTES : 4;

    // Depth of the result queue between parser and output.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Packet type bytes.
    localparam logic [7:0] TYPE_DATA  = 8'h01;
    localparam logic [7:0] TYPE_START = 8'h02;
    localparam logic [7:0] TYPE_END   = 8'h03;

    typedef enum logic [2:0] {
        KIND_PAYLOAD = 3'd0,
        KIND_NAME    = 3'd1,
        KIND_START   = 3'd2,
        KIND_SKIP    = 3'd3,
        KIND_END     = 3'd4,
        KIND_UNKNOWN = 3'd5
    } t_kind;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_CT1   = 4'd1,
        PH_CL1   = 4'd2,
        PH_CSIZE = 4'd3,
        PH_CT2   = 4'd4,
        PH_CL2   = 4'd5,
        PH_CNAME = 4'd6,
        PH_DSEQ  = 4'd7,
        PH_DLHI  = 4'd8,
        PH_DLLO  = 4'd9,
        PH_DPAY  = 4'd10
    } t_phase;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  byte_value;
        logic [31:0] size_value;
        logic [31:0] packets_accepted;
        logic        size_match;
    } t_result;

endpackage

// ===== design/ftpp_front.sv =====
// ----------------------------------------------------------------------------
// ftpp_front
// Byte-serial packet parser: classifies each accepted byte, keeps the
// transfer counters and produces at most one result per byte.
// ----------------------------------------------------------------------------
module ftpp_front
    import ftpp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_packet_start,
    output logic       o_res_valid,
    output t_result    o_res
);

    t_phase      r_phase, n_phase;
    logic [1:0]  r_packet_type, n_packet_type;
    logic [15:0] r_field_counter, n_field_counter;
    logic [7:0]  r_size_len, n_size_len;
    logic [7:0]  r_name_len, n_name_len;
    logic [15:0] r_payload_len, n_payload_len;
    logic        r_seq_ok, n_seq_ok;
    logic [31:0] r_expected_seq, n_expected_seq;
    logic [31:0] r_received_total, n_received_total;
    logic [31:0] r_announced_size, n_announced_size;

    logic [15:0] fc_inc;
    logic [15:0] len_lo;
    logic        is_ctrl;

    assign fc_inc  = r_field_counter + 16'd1;
    assign len_lo  = {r_payload_len[15:8], i_data_byte};
    assign is_ctrl = (i_data_byte == TYPE_START) || (i_data_byte == TYPE_END);

    // Next parse phase.
    always_comb begin
        n_phase = r_phase;
        if (i_packet_start) begin
            if (i_data_byte == TYPE_DATA) begin
                n_phase = PH_DSEQ;
            end else if (is_ctrl) begin
                n_phase = PH_CT1;
            end else begin
                n_phase = PH_IDLE;
            end
        end else begin
            unique case (r_phase)
                PH_CT1:   n_phase = PH_CL1;
                PH_CL1:   n_phase = (i_data_byte == 8'd0) ? PH_CT2 : PH_CSIZE;
                PH_CSIZE: n_phase = (fc_inc >= {8'd0, r_size_len}) ? PH_CT2 : PH_CSIZE;
                PH_CT2:   n_phase = PH_CL2;
                PH_CL2:   n_phase = (i_data_byte == 8'd0) ? PH_IDLE : PH_CNAME;
                PH_CNAME: n_phase = (fc_inc >= {8'd0, r_name_len}) ? PH_IDLE : PH_CNAME;
                PH_DSEQ:  n_phase = PH_DLHI;
                PH_DLHI:  n_phase = PH_DLLO;
                PH_DLLO:  n_phase = (len_lo == 16'd0) ? PH_IDLE : PH_DPAY;
                PH_DPAY:  n_phase = (fc_inc >= r_payload_len) ? PH_IDLE : PH_DPAY;
                default:  n_phase = PH_IDLE;
            endcase
        end
    end

    // Field registers, counters and the result of this byte.
    always_comb begin
        n_packet_type    = r_packet_type;
        n_field_counter  = r_field_counter;
        n_size_len       = r_size_len;
        n_name_len       = r_name_len;
        n_payload_len    = r_payload_len;
        n_seq_ok         = r_seq_ok;
        n_expected_seq   = r_expected_seq;
        n_received_total = r_received_total;
        n_announced_size = r_announced_size;
        o_res_valid           = 1'b0;
        o_res.kind            = KIND_PAYLOAD;
        o_res.byte_value      = 8'd0;
        o_res.size_value      = 32'd0;
        o_res.packets_accepted = r_expected_seq;
        o_res.size_match      = 1'b0;

        if (i_packet_start) begin
            n_field_counter = 16'd0;
            if (i_data_byte == TYPE_DATA) begin
                n_packet_type = TYPE_DATA[1:0];
            end else if (is_ctrl) begin
                n_packet_type = i_data_byte[1:0];
                if (i_data_byte == TYPE_START) begin
                    n_expected_seq   = 32'd0;
                    n_received_total = 32'd0;
                    n_announced_size = 32'd0;
                end
            end else begin
                n_packet_type    = 2'd0;
                o_res_valid      = 1'b1;
                o_res.kind       = KIND_UNKNOWN;
                o_res.byte_value = i_data_byte;
            end
        end else begin
            unique case (r_phase)
                PH_CL1: begin
                    n_size_len      = i_data_byte;
                    n_field_counter = 16'd0;
                end
                PH_CSIZE: begin
                    // Only the leading size bytes of a start packet are kept.
                    for (int k = 0; k < SIZE_TAKE; k++) begin
                        if (r_packet_type == TYPE_START[1:0] && r_field_counter == 16'(k)) begin
                            n_announced_size[8*k +: 8] = r_announced_size[8*k +: 8] | i_data_byte;
                        end
                    end
                    n_field_counter = fc_inc;
                end
                PH_CL2: begin
                    n_name_len      = i_data_byte;
                    n_field_counter = 16'd0;
                    o_res_valid     = 1'b1;
                    if (r_packet_type == TYPE_START[1:0]) begin
                        o_res.kind       = KIND_START;
                        o_res.size_value = r_announced_size;
                    end else begin
                        o_res.kind       = KIND_END;
                        o_res.size_value = r_received_total;
                        o_res.size_match = (r_received_total == r_announced_size);
                    end
                end
                PH_CNAME: begin
                    n_field_counter  = fc_inc;
                    o_res_valid      = 1'b1;
                    o_res.kind       = KIND_NAME;
                    o_res.byte_value = i_data_byte;
                end
                PH_DSEQ: begin
                    n_seq_ok = (i_data_byte == r_expected_seq[7:0]);
                end
                PH_DLHI: begin
                    n_payload_len = {i_data_byte, 8'd0};
                end
                PH_DLLO: begin
                    n_payload_len   = len_lo;
                    n_field_counter = 16'd0;
                    if (r_seq_ok) begin
                        n_expected_seq = r_expected_seq + 32'd1;
                    end else begin
                        o_res_valid = 1'b1;
                        o_res.kind  = KIND_SKIP;
                    end
                end
                PH_DPAY: begin
                    n_field_counter = fc_inc;
                    if (r_seq_ok) begin
                        n_received_total = r_received_total + 32'd1;
                        o_res_valid      = 1'b1;
                        o_res.kind       = KIND_PAYLOAD;
                        o_res.byte_value = i_data_byte;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_IDLE;
            r_packet_type    <= 2'd0;
            r_field_counter  <= 16'd0;
            r_size_len       <= 8'd0;
            r_name_len       <= 8'd0;
            r_payload_len    <= 16'd0;
            r_seq_ok         <= 1'b0;
            r_expected_seq   <= 32'd0;
            r_received_total <= 32'd0;
            r_announced_size <= 32'd0;
        end else if (i_valid) begin
            r_phase          <= n_phase;
            r_packet_type    <= n_packet_type;
            r_field_counter  <= n_field_counter;
            r_size_len       <= n_size_len;
            r_name_len       <= n_name_len;
            r_payload_len    <= n_payload_len;
            r_seq_ok         <= n_seq_ok;
            r_expected_seq   <= n_expected_seq;
            r_received_total <= n_received_total;
            r_announced_size <= n_announced_size;
        end
    end

endmodule

// ===== design/ftpp_result_queue.sv =====
// ----------------------------------------------------------------------------
// ftpp_result_queue
// Small result queue that lets the parser run while the receiver stalls.
// ----------------------------------------------------------------------------
module ftpp_result_queue
    import ftpp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_result i_wr_data,
    input  logic    i_rd,
    output logic    o_full,
    output logic    o_empty,
    output t_result o_head
);

    t_result                r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count, n_count;
    logic                   wr_en;
    logic                   rd_en;

    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = wr_en ? QUEUE_PTR_W'((r_wr_ptr + 1'b1) % QUEUE_DEPTH) : r_wr_ptr;
        n_rd_ptr = rd_en ? QUEUE_PTR_W'((r_rd_ptr + 1'b1) % QUEUE_DEPTH) : r_rd_ptr;
        n_count  = r_count;
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== design/file_transfer_packet_parser.sv =====
// ----------------------------------------------------------------------------
// file_transfer_packet_parser
// Byte-serial parser for start, end and sequenced data packets of a file
// transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Input side: drive i_data_byte and i_packet_start (high on a packet's type
//   byte); a byte is taken on a rising edge with push high and full low.
//   Output side: while empty is low the oldest result is on the o_ ports;
//   pop high at a rising edge takes it.
//   Each byte yields zero or one result. The parser takes one byte per cycle
//   while full is low; a result shows in the cycle after its byte was taken.
//   Results wait in a four-entry queue, so the receiver may stall without
//   holding up the input until four results are pending; full then stays
//   high until a result is popped. Bytes that produce no result never need
//   queue space but are held off by full all the same.
//   Synchronous reset (i_rst_n low) returns the parser to idle, clears the
//   sequence, total and size counters and empties the queue.
// ----------------------------------------------------------------------------
module file_transfer_packet_parser
    import ftpp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_packet_start,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_byte_value,
    output logic [31:0] o_size_value,
    output logic [31:0] o_packets_accepted,
    output logic        o_size_match
);

    logic    accept;
    logic    res_valid;
    t_result res;
    t_result head;

    assign accept = push && !full;

    ftpp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (accept),
        .i_data_byte    (i_data_byte),
        .i_packet_start (i_packet_start),
        .o_res_valid    (res_valid),
        .o_res          (res)
    );

    ftpp_result_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (accept && res_valid),
        .i_wr_data (res),
        .i_rd      (pop),
        .o_full    (full),
        .o_empty   (empty),
        .o_head    (head)
    );

    assign o_kind             = head.kind;
    assign o_byte_value       = head.byte_value;
    assign o_size_value       = head.size_value;
    assign o_packets_accepted = head.packets_accepted;
    assign o_size_match       = head.size_match;

endmodule
